[rtl/bpa_pkg.sv]
`timescale 1ns / 1ps
package bpa_pkg;

  // Region geometry, fixed by the item field widths
  localparam int PAGE_INDEX_BITS = 10;
  localparam int PAGES           = 1 << PAGE_INDEX_BITS;
  localparam int ORD_W           = 4;
  localparam int CNT_W           = PAGE_INDEX_BITS + 1;
  localparam int SIZE_W          = 7;

  // Defaults for the top level parameters
  localparam int PAGE_SHIFT_DEF  = 12;
  localparam int MAX_ORDERS_DEF  = 32;

  typedef logic [PAGE_INDEX_BITS-1:0] page_t;
  typedef logic [ORD_W-1:0]           order_t;
  typedef logic [CNT_W-1:0]           count_t;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_MEM      = 2'd1,
    STAT_DOUBLE_FREE = 2'd2,
    STAT_NOT_HEAD    = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] request_bytes;
    logic [7:0]  owner_flags;
    page_t       page_index;
  } req_t;

  typedef struct packed {
    status_t    status;
    page_t      block_page;
    order_t     block_order;
    logic       page_is_free;
    logic [7:0] page_flag_bits;
    count_t     free_pages;
    count_t     used_pages;
  } rsp_t;

  // Per-page metadata word
  typedef struct packed {
    logic   free;
    logic   head;
    order_t order;
  } meta_t;

  // Access bundle from the sequencer to the page store
  typedef struct packed {
    logic       meta_we;
    page_t      meta_waddr;
    meta_t      meta_wdata;
    page_t      meta_raddr;
    logic       flag_we;
    page_t      flag_waddr;
    logic [7:0] flag_wdata;
    page_t      flag_raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SIZE,
    S_WALK_RD,
    S_WALK_CHK,
    S_SPLIT,
    S_MARK,
    S_FREE_RD,
    S_FREE_CHK,
    S_FILL,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_MERGE_LOW,
    S_QUERY_RD,
    S_QUERY_CHK,
    S_RESP
  } state_t;

endpackage

[rtl/bpa_size.sv]
`timescale 1ns / 1ps
module bpa_size
  import bpa_pkg::*;
#(
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
  parameter int MAX_ORDERS = MAX_ORDERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] bytes,
  output logic        done,
  output logic        fail,
  output order_t      need
);

  logic [SIZE_W-1:0] bpos;
  logic [31:0]       bytes_q;
  logic              run;
  logic [32:0]       pow;
  logic              too_big;
  logic              fits;

  // One bit position per cycle, starting at one page
  assign pow     = 33'(1) << bpos;
  assign too_big = (bpos >= SIZE_W'(MAX_ORDERS)) ||
                   (bpos > SIZE_W'(PAGE_SHIFT + PAGE_INDEX_BITS));
  assign fits    = pow >= {1'b0, bytes_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run     <= 1'b1;
        bpos    <= SIZE_W'(PAGE_SHIFT);
        bytes_q <= bytes;
      end else if (run) begin
        if (too_big) begin
          run  <= 1'b0;
          done <= 1'b1;
          fail <= 1'b1;
        end else if (fits) begin
          run  <= 1'b0;
          done <= 1'b1;
          fail <= 1'b0;
          need <= order_t'(bpos - SIZE_W'(PAGE_SHIFT));
        end else begin
          bpos <= bpos + SIZE_W'(1);
        end
      end
    end
  end

endmodule

[rtl/bpa_store.sv]
`timescale 1ns / 1ps
module bpa_store
  import bpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  mem_req_t   mreq,
  output logic       ready,
  output meta_t      meta_rd,
  output logic [7:0] flag_rd
);

  meta_t      meta_mem [PAGES];
  logic [7:0] flag_mem [PAGES];
  page_t      clr_cnt;
  logic       clearing;
  meta_t      clr_meta;

  // Clearing pass after reset: one page per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + page_t'(1);
      if (clr_cnt == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  assign clr_meta.free  = 1'b1;
  assign clr_meta.head  = (clr_cnt == '0);
  assign clr_meta.order = (clr_cnt == '0) ? order_t'(PAGE_INDEX_BITS) : '0;
  assign ready          = !clearing;

  // Metadata memory
  always_ff @(posedge clk) begin
    if (clearing) begin
      meta_mem[clr_cnt] <= clr_meta;
    end else if (mreq.meta_we) begin
      meta_mem[mreq.meta_waddr] <= mreq.meta_wdata;
    end
    meta_rd <= meta_mem[mreq.meta_raddr];
  end

  // Owner flag memory
  always_ff @(posedge clk) begin
    if (clearing) begin
      flag_mem[clr_cnt] <= '0;
    end else if (mreq.flag_we) begin
      flag_mem[mreq.flag_waddr] <= mreq.flag_wdata;
    end
    flag_rd <= flag_mem[mreq.flag_raddr];
  end

endmodule

[rtl/buddy_page_allocator.sv]
`timescale 1ns / 1ps
// Steps: a query reads the page store; an unknown command or an error goes straight
//   to the result; a free reads the head, fills the block, then merges while its buddy
//   is free; an allocate sizes the request, walks the blocks, splits the chosen one
//   and marks its pages. A result held by rsp_ready adds its stall.
// Throughput: one item at a time; the block returns to idle for the next item once the
//   result loads, and the walk, fill and mark passes over the page store set the length.
// Reset: synchronous; a clearing pass over all 1024 pages rewrites the page store
//   (region free as one block, no flags) before the first item is taken.
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
  parameter int MAX_ORDERS = MAX_ORDERS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t     state, state_next;
  mem_req_t   mreq;
  logic       store_ready;
  meta_t      meta_rd;
  logic [7:0] flag_rd;
  logic       size_start, size_done, size_fail;
  order_t     size_need;

  logic [7:0] flags;
  page_t      page, pick, wr_addr;
  order_t     need, ord, best_ord, h;
  logic       found, wr_pend;
  count_t     walk_p, cnt, free_cnt, used_cnt;
  status_t    r_status;
  page_t      r_page;
  order_t     r_order;
  logic       r_free;
  logic [7:0] r_flags;

  count_t     walk_next, n_alloc, n_free;
  logic       walk_end, cand, exact, found_now, merge_ok, mark_done, rsp_load;
  page_t      ord_bit;
  order_t     ord_clamp;

  bpa_size #(
    .PAGE_SHIFT(PAGE_SHIFT),
    .MAX_ORDERS(MAX_ORDERS)
  ) u_size (
    .clk  (clk),
    .rst  (rst),
    .start(size_start),
    .bytes(req.request_bytes),
    .done (size_done),
    .fail (size_fail),
    .need (size_need)
  );

  bpa_store u_store (
    .clk    (clk),
    .rst    (rst),
    .mreq   (mreq),
    .ready  (store_ready),
    .meta_rd(meta_rd),
    .flag_rd(flag_rd)
  );

  // Block walk and search terms
  assign walk_next = walk_p + (count_t'(1) << meta_rd.order);
  assign walk_end  = walk_next[CNT_W-1];
  assign cand      = meta_rd.free && meta_rd.head && (meta_rd.order >= need) &&
                     (!found || (meta_rd.order < best_ord));
  assign exact     = cand && (meta_rd.order == need);
  assign found_now = found || cand;
  assign n_alloc   = count_t'(1) << need;
  assign n_free    = count_t'(1) << ord;
  assign ord_bit   = page_t'(count_t'(1) << ord);
  assign merge_ok  = meta_rd.free && meta_rd.head && (meta_rd.order == ord);
  assign mark_done = (cnt == n_alloc) && !wr_pend;
  assign ord_clamp = (meta_rd.order > order_t'(PAGE_INDEX_BITS)) ?
                     order_t'(PAGE_INDEX_BITS) : meta_rd.order;
  assign rsp_load  = (state == S_RESP) && (!rsp_valid || rsp_ready);

  assign req_ready  = (state == S_IDLE);
  assign size_start = req_valid && req_ready && (req.command == CMD_ALLOC);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:      if (store_ready) state_next = S_IDLE;
      S_IDLE: begin
        if (req_valid) begin
          case (req.command)
            CMD_ALLOC: state_next = S_SIZE;
            CMD_FREE:  state_next = S_FREE_RD;
            CMD_QUERY: state_next = S_QUERY_RD;
            default:   state_next = S_RESP;
          endcase
        end
      end
      S_SIZE: begin
        if (size_done) state_next = size_fail ? S_RESP : S_WALK_RD;
      end
      S_WALK_RD:   state_next = S_WALK_CHK;
      S_WALK_CHK: begin
        if (exact || walk_end) begin
          state_next = found_now ? S_SPLIT : S_RESP;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_SPLIT:     if (h == best_ord) state_next = S_MARK;
      S_MARK:      if (mark_done) state_next = S_RESP;
      S_FREE_RD:   state_next = S_FREE_CHK;
      S_FREE_CHK: begin
        state_next = (meta_rd.free || !meta_rd.head) ? S_RESP : S_FILL;
      end
      S_FILL:      if (cnt == n_free - count_t'(1)) state_next = S_MERGE_RD;
      S_MERGE_RD: begin
        state_next = (ord >= order_t'(PAGE_INDEX_BITS)) ? S_RESP : S_MERGE_CHK;
      end
      S_MERGE_CHK: state_next = merge_ok ? S_MERGE_LOW : S_RESP;
      S_MERGE_LOW: state_next = S_MERGE_RD;
      S_QUERY_RD:  state_next = S_QUERY_CHK;
      S_QUERY_CHK: state_next = S_RESP;
      S_RESP:      if (rsp_load) state_next = S_IDLE;
      default:     state_next = S_INIT;
    endcase
  end

  // Page store accesses
  always_comb begin
    mreq = '0;
    case (state)
      S_WALK_RD: mreq.meta_raddr = walk_p[PAGE_INDEX_BITS-1:0];
      S_SPLIT: begin
        if (h != best_ord) begin
          mreq.meta_we    = 1'b1;
          mreq.meta_waddr = pick + page_t'(count_t'(1) << h);
          mreq.meta_wdata = meta_t'{free: 1'b1, head: 1'b1, order: h};
        end
      end
      S_MARK: begin
        if (cnt != n_alloc) begin
          mreq.meta_we    = 1'b1;
          mreq.meta_waddr = pick + cnt[PAGE_INDEX_BITS-1:0];
          mreq.meta_wdata = (cnt == '0) ? meta_t'{free: 1'b0, head: 1'b1, order: need}
                                        : meta_t'('0);
          mreq.flag_raddr = pick + cnt[PAGE_INDEX_BITS-1:0];
        end
        if (wr_pend) begin
          mreq.flag_we    = 1'b1;
          mreq.flag_waddr = wr_addr;
          mreq.flag_wdata = flag_rd | flags;
        end
      end
      S_FREE_RD: mreq.meta_raddr = page;
      S_FILL: begin
        mreq.meta_we    = 1'b1;
        mreq.meta_waddr = page + cnt[PAGE_INDEX_BITS-1:0];
        mreq.meta_wdata = (cnt == '0) ? meta_t'{free: 1'b1, head: 1'b1, order: ord}
                                      : meta_t'{free: 1'b1, head: 1'b0, order: '0};
      end
      S_MERGE_RD: mreq.meta_raddr = page ^ ord_bit;
      S_MERGE_CHK: begin
        // upper half loses its head
        if (merge_ok) begin
          mreq.meta_we    = 1'b1;
          mreq.meta_waddr = page | ord_bit;
          mreq.meta_wdata = meta_t'{free: 1'b1, head: 1'b0, order: '0};
        end
      end
      S_MERGE_LOW: begin
        mreq.meta_we    = 1'b1;
        mreq.meta_waddr = page & ~ord_bit;
        mreq.meta_wdata = meta_t'{free: 1'b1, head: 1'b1, order: ord + order_t'(1)};
      end
      S_QUERY_RD: begin
        mreq.meta_raddr = page;
        mreq.flag_raddr = page;
      end
      default: mreq = '0;
    endcase
  end

  // Datapath and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      free_cnt  <= count_t'(PAGES);
      used_cnt  <= '0;
      wr_pend   <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !rsp_load) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            flags    <= req.owner_flags;
            page     <= req.page_index;
            r_status <= STAT_OK;
            r_page   <= '0;
            r_order  <= '0;
            r_free   <= 1'b0;
            r_flags  <= '0;
            found    <= 1'b0;
            walk_p   <= '0;
            cnt      <= '0;
            wr_pend  <= 1'b0;
          end
        end
        S_SIZE: begin
          if (size_done) begin
            need <= size_need;
            if (size_fail) r_status <= STAT_NO_MEM;
          end
        end
        S_WALK_CHK: begin
          if (cand) begin
            found    <= 1'b1;
            best_ord <= meta_rd.order;
            pick     <= walk_p[PAGE_INDEX_BITS-1:0];
          end
          walk_p <= walk_next;
          h      <= need;
          if ((exact || walk_end) && !found_now) r_status <= STAT_NO_MEM;
        end
        S_SPLIT: if (h != best_ord) h <= h + order_t'(1);
        S_MARK: begin
          // flag read-modify-write runs one page behind the metadata write
          wr_pend <= (cnt != n_alloc);
          wr_addr <= pick + cnt[PAGE_INDEX_BITS-1:0];
          if (cnt != n_alloc) cnt <= cnt + count_t'(1);
          if (mark_done) begin
            free_cnt <= free_cnt - n_alloc;
            used_cnt <= used_cnt + n_alloc;
            r_page   <= pick;
            r_order  <= need;
          end
        end
        S_FREE_CHK: begin
          if (meta_rd.free) begin
            r_status <= STAT_DOUBLE_FREE;
          end else if (!meta_rd.head) begin
            r_status <= STAT_NOT_HEAD;
          end else begin
            ord <= ord_clamp;
          end
        end
        S_FILL: begin
          cnt <= cnt + count_t'(1);
          if (cnt == n_free - count_t'(1)) begin
            free_cnt <= free_cnt + n_free;
            used_cnt <= used_cnt - n_free;
            r_page   <= page;
            r_order  <= ord;
          end
        end
        S_MERGE_LOW: begin
          page <= page & ~ord_bit;
          ord  <= ord + order_t'(1);
        end
        S_QUERY_CHK: begin
          r_page  <= page;
          r_order <= meta_rd.head ? meta_rd.order : '0;
          r_free  <= meta_rd.free;
          r_flags <= flag_rd;
        end
        S_RESP: begin
          if (rsp_load) begin
            rsp_valid          <= 1'b1;
            rsp.status         <= r_status;
            rsp.block_page     <= r_page;
            rsp.block_order    <= r_order;
            rsp.page_is_free   <= r_free;
            rsp.page_flag_bits <= r_flags;
            rsp.free_pages     <= free_cnt;
            rsp.used_pages     <= used_cnt;
          end
        end
        default: ;
      endcase
    end
  end

  // Page accounting stays balanced
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, free_cnt} + {1'b0, used_cnt}) == (CNT_W + 1)'(PAGES))
    else $error("free and used page counts do not sum to region size");

  // No store writes while the clearing pass owns the memories
  assert property (@(posedge clk) disable iff (rst)
    (mreq.meta_we || mreq.flag_we) |-> store_ready)
    else $error("page store written during clearing pass");

  // Split never runs past the order of the chosen block
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT) |-> (h <= best_ord))
    else $error("split order beyond chosen block");

  // A new result only appears from the response state
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_RESP))
    else $error("result raised outside response state");

endmodule
